### rtl/core/rv64_instruction_encoder_defines.svh
// ----------------------------------------------------------------------------
// rv64 instruction encoder assertion macros
// shared property forms for the encoder checker
// ----------------------------------------------------------------------------
`ifndef RV64_INSTRUCTION_ENCODER_DEFINES_SVH
`define RV64_INSTRUCTION_ENCODER_DEFINES_SVH

// same-cycle implication under reset
`define RV64IE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define RV64IE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/rv64ie_pkg.sv
// ----------------------------------------------------------------------------
// rv64ie package
// field widths, mnemonic codes, opcodes and the decode record
// ----------------------------------------------------------------------------
package rv64ie_pkg;

	localparam int CMD_W  = 6;
	localparam int REG_W  = 5;
	localparam int WORD_W = 32;
	localparam int KIND_W = 2;
	localparam int FMT_W  = 3;
	localparam int OP_W   = 7;
	localparam int F3_W   = 3;
	localparam int F7_W   = 7;

	// formats
	localparam logic [FMT_W-1:0] FMT_R  = 3'd0;
	localparam logic [FMT_W-1:0] FMT_I  = 3'd1;
	localparam logic [FMT_W-1:0] FMT_S  = 3'd2;
	localparam logic [FMT_W-1:0] FMT_SB = 3'd3;
	localparam logic [FMT_W-1:0] FMT_U  = 3'd4;
	localparam logic [FMT_W-1:0] FMT_UJ = 3'd5;

	// operand kinds
	localparam logic [KIND_W-1:0] KIND_IMM   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LABEL = 2'd1;

	// opcodes
	localparam logic [OP_W-1:0] OP_RR   = 7'b0110011;
	localparam logic [OP_W-1:0] OP_RRW  = 7'b0111011;
	localparam logic [OP_W-1:0] OP_IMM  = 7'b0010011;
	localparam logic [OP_W-1:0] OP_IMMW = 7'b0011011;
	localparam logic [OP_W-1:0] OP_LOAD = 7'b0000011;
	localparam logic [OP_W-1:0] OP_JALR = 7'b1100111;
	localparam logic [OP_W-1:0] OP_STOR = 7'b0100011;
	localparam logic [OP_W-1:0] OP_BRAN = 7'b1100011;
	localparam logic [OP_W-1:0] OP_LUI  = 7'b0110111;
	localparam logic [OP_W-1:0] OP_AUIP = 7'b0010111;
	localparam logic [OP_W-1:0] OP_JAL  = 7'b1101111;

	localparam logic [F7_W-1:0] F7_BASE = 7'b0000000;
	localparam logic [F7_W-1:0] F7_ALT  = 7'b0100000;
	localparam logic [F7_W-1:0] F7_MUL  = 7'b0000001;

	// mnemonic codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 6'd0;
	localparam logic [CMD_W-1:0] CMD_ADDW  = 6'd1;
	localparam logic [CMD_W-1:0] CMD_AND   = 6'd2;
	localparam logic [CMD_W-1:0] CMD_OR    = 6'd3;
	localparam logic [CMD_W-1:0] CMD_SLL   = 6'd4;
	localparam logic [CMD_W-1:0] CMD_SLT   = 6'd5;
	localparam logic [CMD_W-1:0] CMD_SRA   = 6'd6;
	localparam logic [CMD_W-1:0] CMD_SRL   = 6'd7;
	localparam logic [CMD_W-1:0] CMD_SUB   = 6'd8;
	localparam logic [CMD_W-1:0] CMD_SUBW  = 6'd9;
	localparam logic [CMD_W-1:0] CMD_XOR   = 6'd10;
	localparam logic [CMD_W-1:0] CMD_MUL   = 6'd11;
	localparam logic [CMD_W-1:0] CMD_MULW  = 6'd12;
	localparam logic [CMD_W-1:0] CMD_DIV   = 6'd13;
	localparam logic [CMD_W-1:0] CMD_DIVW  = 6'd14;
	localparam logic [CMD_W-1:0] CMD_REM   = 6'd15;
	localparam logic [CMD_W-1:0] CMD_REMW  = 6'd16;
	localparam logic [CMD_W-1:0] CMD_ADDI  = 6'd17;
	localparam logic [CMD_W-1:0] CMD_ADDIW = 6'd18;
	localparam logic [CMD_W-1:0] CMD_ANDI  = 6'd19;
	localparam logic [CMD_W-1:0] CMD_ORI   = 6'd20;
	localparam logic [CMD_W-1:0] CMD_LB    = 6'd21;
	localparam logic [CMD_W-1:0] CMD_LH    = 6'd22;
	localparam logic [CMD_W-1:0] CMD_LW    = 6'd23;
	localparam logic [CMD_W-1:0] CMD_LD    = 6'd24;
	localparam logic [CMD_W-1:0] CMD_JALR  = 6'd25;
	localparam logic [CMD_W-1:0] CMD_SB    = 6'd26;
	localparam logic [CMD_W-1:0] CMD_SH    = 6'd27;
	localparam logic [CMD_W-1:0] CMD_SW    = 6'd28;
	localparam logic [CMD_W-1:0] CMD_SD    = 6'd29;
	localparam logic [CMD_W-1:0] CMD_BEQ   = 6'd30;
	localparam logic [CMD_W-1:0] CMD_BNE   = 6'd31;
	localparam logic [CMD_W-1:0] CMD_BLT   = 6'd32;
	localparam logic [CMD_W-1:0] CMD_BGE   = 6'd33;
	localparam logic [CMD_W-1:0] CMD_LUI   = 6'd34;
	localparam logic [CMD_W-1:0] CMD_AUIPC = 6'd35;
	localparam logic [CMD_W-1:0] CMD_JAL   = 6'd36;

	typedef struct packed {
		logic             known;
		logic [FMT_W-1:0] fmt;
		logic [OP_W-1:0]  opcode;
		logic [F3_W-1:0]  funct3;
		logic [F7_W-1:0]  funct7;
	} dec_t;

endpackage

### rtl/core/rv64ie_decode.sv
// ----------------------------------------------------------------------------
// rv64ie decode
// mnemonic code to format, opcode, funct3 and funct7
// ----------------------------------------------------------------------------
module rv64ie_decode (
	input  logic [rv64ie_pkg::CMD_W-1:0] command,
	output rv64ie_pkg::dec_t              dec
);
	import rv64ie_pkg::*;

	always_comb begin
		dec = '{known: 1'b1, fmt: FMT_R, opcode: OP_RR, funct3: 3'd0, funct7: F7_BASE};
		unique case (command) inside
			CMD_ADD, CMD_SLL, CMD_SLT, CMD_SRL, CMD_AND, CMD_OR, CMD_XOR,
			CMD_SRA, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM: begin
				dec.fmt = FMT_R;
			end
			CMD_ADDW, CMD_SUBW, CMD_MULW, CMD_DIVW, CMD_REMW: begin
				dec.opcode = OP_RRW;
			end
			[CMD_ADDI:CMD_ORI]: begin
				dec.fmt = FMT_I;
				dec.opcode = (command == CMD_ADDIW) ? OP_IMMW : OP_IMM;
			end
			[CMD_LB:CMD_LD]: begin
				dec.fmt = FMT_I;
				dec.opcode = OP_LOAD;
			end
			CMD_JALR: begin
				dec.fmt = FMT_I;
				dec.opcode = OP_JALR;
			end
			[CMD_SB:CMD_SD]: begin
				dec.fmt = FMT_S;
				dec.opcode = OP_STOR;
			end
			[CMD_BEQ:CMD_BGE]: begin
				dec.fmt = FMT_SB;
				dec.opcode = OP_BRAN;
			end
			CMD_LUI: begin
				dec.fmt = FMT_U;
				dec.opcode = OP_LUI;
			end
			CMD_AUIPC: begin
				dec.fmt = FMT_U;
				dec.opcode = OP_AUIP;
			end
			CMD_JAL: begin
				dec.fmt = FMT_UJ;
				dec.opcode = OP_JAL;
			end
			default: begin
				dec.known = 1'b0;
			end
		endcase

		case (command) inside
			CMD_AND, CMD_ANDI:                        dec.funct3 = 3'd7;
			CMD_OR, CMD_REM, CMD_REMW, CMD_ORI:       dec.funct3 = 3'd6;
			CMD_SLL, CMD_LH, CMD_SH, CMD_BNE:         dec.funct3 = 3'd1;
			CMD_SLT, CMD_LW, CMD_SW:                  dec.funct3 = 3'd2;
			CMD_SRA, CMD_SRL, CMD_BGE:                dec.funct3 = 3'd5;
			CMD_XOR, CMD_DIV, CMD_DIVW, CMD_BLT:      dec.funct3 = 3'd4;
			CMD_LD, CMD_SD:                           dec.funct3 = 3'd3;
			default:                                  dec.funct3 = 3'd0;
		endcase

		case (command) inside
			CMD_SRA, CMD_SUB, CMD_SUBW:               dec.funct7 = F7_ALT;
			[CMD_MUL:CMD_REMW]:                       dec.funct7 = F7_MUL;
			default:                                  dec.funct7 = F7_BASE;
		endcase

		if (!dec.known) begin
			dec.opcode = '0;
			dec.funct3 = '0;
			dec.funct7 = '0;
			dec.fmt    = FMT_R;
		end
	end

endmodule

### rtl/core/rv64ie_pack.sv
// ----------------------------------------------------------------------------
// rv64ie pack
// immediate selection and instruction word assembly per format
// ----------------------------------------------------------------------------
module rv64ie_pack (
	input  rv64ie_pkg::dec_t               dec,
	input  logic [rv64ie_pkg::REG_W-1:0]   dest_reg,
	input  logic [rv64ie_pkg::REG_W-1:0]   src1_reg,
	input  logic [rv64ie_pkg::REG_W-1:0]   src2_reg,
	input  logic signed [rv64ie_pkg::WORD_W-1:0] imm_value,
	input  logic [rv64ie_pkg::KIND_W-1:0]  operand_kind,
	input  logic [rv64ie_pkg::WORD_W-1:0]  label_address,
	input  logic [rv64ie_pkg::WORD_W-1:0]  pc,
	output logic [rv64ie_pkg::WORD_W-1:0]  word
);
	import rv64ie_pkg::*;

	logic [WORD_W-1:0] imm;
	logic              pc_rel;

	assign pc_rel = (dec.fmt == FMT_SB) || (dec.fmt == FMT_UJ);

	always_comb begin
		case (operand_kind)
			KIND_IMM:   imm = $unsigned(imm_value);
			KIND_LABEL: imm = pc_rel ? (label_address - pc) : label_address;
			default:    imm = '0;
		endcase
	end

	always_comb begin
		word = '0;
		if (dec.known) begin
			case (dec.fmt)
				FMT_R:  word = {dec.funct7, src2_reg, src1_reg, dec.funct3, dest_reg,
					dec.opcode};
				FMT_I:  word = {imm[11:0], src1_reg, dec.funct3, dest_reg, dec.opcode};
				FMT_S:  word = {imm[11:5], src2_reg, src1_reg, dec.funct3, imm[4:0],
					dec.opcode};
				FMT_SB: word = {imm[12], imm[10:5], src2_reg, src1_reg, dec.funct3,
					imm[4:1], imm[11], dec.opcode};
				FMT_U:  word = {imm[31:12], dest_reg, dec.opcode};
				FMT_UJ: word = {imm[20], imm[10:1], imm[11], imm[19:12], dest_reg,
					dec.opcode};
				default: word = '0;
			endcase
		end
	end

endmodule

### rtl/core/rv64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// rv64 instruction encoder
// encodes one parsed rv64im instruction into its 32-bit machine word
// ----------------------------------------------------------------------------
// takes one item per clock while results are taken; an accepted item passes
// through the input register and then the result register, the two stages,
// with decode and packing between them, so at most two items are held; a
// stalled result stops the next item only once the input register is full
module rv64_instruction_encoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  logic [rv64ie_pkg::CMD_W-1:0]         command,
	input  logic [rv64ie_pkg::REG_W-1:0]         dest_reg,
	input  logic [rv64ie_pkg::REG_W-1:0]         src1_reg,
	input  logic [rv64ie_pkg::REG_W-1:0]         src2_reg,
	input  logic signed [rv64ie_pkg::WORD_W-1:0] imm_value,
	input  logic [rv64ie_pkg::KIND_W-1:0]        operand_kind,
	input  logic [rv64ie_pkg::WORD_W-1:0]        label_address,
	input  logic [rv64ie_pkg::WORD_W-1:0]        pc,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic [rv64ie_pkg::WORD_W-1:0]        instr_word,
	output logic [rv64ie_pkg::FMT_W-1:0]         format_code,
	output logic                                 valid_res
);
	import rv64ie_pkg::*;

	logic                     valid_s1;
	logic [CMD_W-1:0]         command_s1;
	logic [REG_W-1:0]         dest_reg_s1;
	logic [REG_W-1:0]         src1_reg_s1;
	logic [REG_W-1:0]         src2_reg_s1;
	logic signed [WORD_W-1:0] imm_value_s1;
	logic [KIND_W-1:0]        operand_kind_s1;
	logic [WORD_W-1:0]        label_address_s1;
	logic [WORD_W-1:0]        pc_s1;

	logic                     valid_s2;
	logic [WORD_W-1:0]        word_s2;
	logic [FMT_W-1:0]         fmt_s2;
	logic                     known_s2;

	dec_t                     dec;
	logic [WORD_W-1:0]        word;
	logic                     load_s2;
	logic                     take;

	assign load_s2   = valid_s1 && (!valid_s2 || res_ready);
	assign cmd_ready = !valid_s1 || load_s2;
	assign take      = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			command_s1       <= command;
			dest_reg_s1      <= dest_reg;
			src1_reg_s1      <= src1_reg;
			src2_reg_s1      <= src2_reg;
			imm_value_s1     <= imm_value;
			operand_kind_s1  <= operand_kind;
			label_address_s1 <= label_address;
			pc_s1            <= pc;
		end
	end

	rv64ie_decode u_decode (
		.command (command_s1),
		.dec     (dec)
	);

	rv64ie_pack u_pack (
		.dec           (dec),
		.dest_reg      (dest_reg_s1),
		.src1_reg      (src1_reg_s1),
		.src2_reg      (src2_reg_s1),
		.imm_value     (imm_value_s1),
		.operand_kind  (operand_kind_s1),
		.label_address (label_address_s1),
		.pc            (pc_s1),
		.word          (word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			word_s2  <= word;
			fmt_s2   <= dec.fmt;
			known_s2 <= dec.known;
		end
	end

	assign res_valid   = valid_s2;
	assign instr_word  = word_s2;
	assign format_code = fmt_s2;
	assign valid_res   = known_s2;

endmodule

### rtl/core/rv64ie_checker.sv
// ----------------------------------------------------------------------------
// rv64ie checker
// port-level properties of the encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "rv64_instruction_encoder_defines.svh"

module rv64ie_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 res_valid,
	input logic                                 res_ready,
	input logic [rv64ie_pkg::WORD_W-1:0]        instr_word,
	input logic [rv64ie_pkg::FMT_W-1:0]         format_code,
	input logic                                 valid_res
);
	import rv64ie_pkg::*;

	`RV64IE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(instr_word) && $stable(format_code) && $stable(valid_res),
		"stalled result item changed")
	`RV64IE_ASSERT_IMPLY(a_unknown_zero, clk, arst_n, res_valid && !valid_res,
		instr_word == '0 && format_code == FMT_R, "unknown mnemonic gave a nonzero item")
	`RV64IE_ASSERT_IMPLY(a_fmt_range, clk, arst_n, res_valid && valid_res,
		format_code <= FMT_UJ, "format code out of range")
	`RV64IE_ASSERT_IMPLY(a_r_opcode, clk, arst_n, res_valid && valid_res && format_code == FMT_R,
		instr_word[6:0] == OP_RR || instr_word[6:0] == OP_RRW, "bad opcode for r format")

endmodule

bind rv64_instruction_encoder rv64ie_checker u_checker (.*);
